@@ design/apcu_pkg.sv @@
// Shared types, constants and fixed-point helpers for the Aliev-Panfilov cell update.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package apcu_pkg;

  localparam int FRAC_BITS = 24;
  localparam int NUM_W = 32 + FRAC_BITS;
  localparam int DIV_STEPS = 32;
  localparam int DEN_W = 33;

  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;

  localparam logic [3:0] REG_ALPHA = 4'd0;
  localparam logic [3:0] REG_DT    = 4'd1;
  localparam logic [3:0] REG_KK    = 4'd2;
  localparam logic [3:0] REG_TA    = 4'd3;
  localparam logic [3:0] REG_TB    = 4'd4;
  localparam logic [3:0] REG_EPS   = 4'd5;
  localparam logic [3:0] REG_M1    = 4'd6;
  localparam logic [3:0] REG_M2    = 4'd7;

  localparam logic [30:0] RST_ALPHA = 31'd0;
  localparam logic [30:0] RST_DT    = 31'd0;
  localparam logic [30:0] RST_KK    = 31'd134217728;
  localparam logic [30:0] RST_TA    = 31'd1677722;
  localparam logic [30:0] RST_TB    = 31'd1677722;
  localparam logic [30:0] RST_EPS   = 31'd167772;
  localparam logic [30:0] RST_M1    = 31'd1174405;
  localparam logic [30:0] RST_M2    = 31'd5033165;

  typedef struct packed {
    logic [30:0] alpha;
    logic [30:0] dt;
    logic [30:0] kk;
    logic [30:0] ta;
    logic [30:0] tb;
    logic [30:0] eps;
    logic [30:0] m1;
    logic [30:0] m2;
  } cfg_t;

  typedef struct packed {
    logic               clip;
    logic signed [31:0] v;
  } sat_t;

  typedef struct packed {
    logic               clip;
    logic               m1r_clip;
    logic               fault;
    logic               neg;
    logic               ovf;
    logic signed [31:0] ec;
    logic signed [31:0] r;
    logic signed [31:0] ec_a;
    logic signed [31:0] ec_1;
    logic signed [31:0] ec_b;
    logic signed [31:0] negr;
    logic signed [31:0] lapc;
    logic signed [31:0] kke;
    logic signed [31:0] er;
    logic signed [31:0] m1r;
    logic signed [31:0] rate;
    logic signed [31:0] e1;
    logic signed [31:0] t1;
    logic signed [31:0] t2;
    logic signed [31:0] drive;
    logic signed [31:0] dtrate;
    logic signed [31:0] react2;
    logic signed [31:0] e_new;
    logic signed [31:0] r_new;
    logic signed [35:0] nsum;
    logic signed [33:0] den;
    logic signed [63:0] p_kke;
    logic signed [63:0] p_er;
    logic signed [63:0] p_m1r;
    logic signed [63:0] p_alap;
    logic signed [63:0] p_t1;
    logic signed [63:0] p_t2;
    logic signed [63:0] p_dtrate;
    logic signed [63:0] p_react;
    logic signed [63:0] p_dtr;
    logic signed [63:0] p_rd;
    logic [NUM_W-1:0]   num_mag;
    logic [DEN_W-1:0]   den_mag;
    logic [DEN_W-1:0]   rem;
    logic [DIV_STEPS-1:0] quo;
  } pipe_t;

  function automatic sat_t sat32(input logic signed [65:0] v);
    sat_t s;
    if (v > 66'(Q_MAX)) begin
      s.clip = 1'b1;
      s.v = Q_MAX;
    end else if (v < 66'(Q_MIN)) begin
      s.clip = 1'b1;
      s.v = Q_MIN;
    end else begin
      s.clip = 1'b0;
      s.v = v[31:0];
    end
    return s;
  endfunction

  function automatic logic signed [65:0] sx(input logic signed [31:0] a);
    return 66'(a);
  endfunction

  function automatic logic signed [31:0] ureg(input logic [30:0] a);
    return $signed({1'b0, a});
  endfunction

  function automatic logic signed [63:0] mul64(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    return 64'(a) * 64'(b);
  endfunction

  function automatic sat_t qmul(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p >>> FRAC_BITS;
    return sat32(66'(s));
  endfunction

endpackage

@@ design/apcu_front.sv @@
// Front stages: stencil sum, first products and divider operand preparation.
// Three register stages; depends on apcu_pkg.
`timescale 1ns / 1ps

module apcu_front import apcu_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  cfg_t               cfg,
  input  logic               in_valid,
  input  logic signed [31:0] e_center,
  input  logic signed [31:0] e_north,
  input  logic signed [31:0] e_south,
  input  logic signed [31:0] e_east,
  input  logic signed [31:0] e_west,
  input  logic signed [31:0] recovery_in,
  output logic               out_valid,
  output pipe_t              out_data
);

  pipe_t s1, s2, s3;
  pipe_t s1_next, s2_next, s3_next;
  logic  v1, v2;

  always_comb begin
    sat_t t;
    s1_next = '0;
    s1_next.ec = e_center;
    s1_next.r = recovery_in;
    s1_next.nsum = 36'(e_north) + 36'(e_south) + 36'(e_east) + 36'(e_west)
                   - (36'(e_center) <<< 2);
    s1_next.p_kke = mul64(ureg(cfg.kk), e_center);
    s1_next.p_er = mul64(e_center, recovery_in);
    s1_next.p_m1r = mul64(ureg(cfg.m1), recovery_in);
    s1_next.den = 34'(e_center) + 34'(ureg(cfg.m2));
    t = sat32(sx(e_center) - sx(ureg(cfg.ta)));
    s1_next.ec_a = t.v;
    s1_next.clip = t.clip;
    t = sat32(sx(e_center) - sx(ONE));
    s1_next.ec_1 = t.v;
    s1_next.clip = s1_next.clip | t.clip;
    t = sat32(sx(e_center) - sx(ureg(cfg.tb)));
    s1_next.ec_b = t.v;
    s1_next.clip = s1_next.clip | t.clip;
    t = sat32(-sx(recovery_in));
    s1_next.negr = t.v;
    s1_next.clip = s1_next.clip | t.clip;
  end

  always_comb begin
    sat_t t;
    s2_next = s1;
    t = sat32(66'(s1.nsum));
    s2_next.lapc = t.v;
    s2_next.clip = s2_next.clip | t.clip;
    t = qmul(s1.p_kke);
    s2_next.kke = t.v;
    s2_next.clip = s2_next.clip | t.clip;
    t = qmul(s1.p_er);
    s2_next.er = t.v;
    s2_next.clip = s2_next.clip | t.clip;
    t = qmul(s1.p_m1r);
    s2_next.m1r = t.v;
    s2_next.m1r_clip = t.clip;
    t = sat32(sx(s1.ec_b) - sx(ONE));
    s2_next.ec_b = t.v;
    s2_next.clip = s2_next.clip | t.clip;
    s2_next.fault = (s1.den == 34'sd0);
  end

  always_comb begin
    logic [32:0] m_abs;
    logic [63:0] shifted;
    s3_next = s2;
    m_abs = s2.m1r[31] ? 33'(-34'(s2.m1r)) : 33'(s2.m1r);
    shifted = 64'(m_abs) << FRAC_BITS;
    s3_next.num_mag = shifted[NUM_W-1:0];
    s3_next.den_mag = s2.den[33] ? DEN_W'(-s2.den) : DEN_W'(s2.den);
    s3_next.neg = s2.m1r[31] ^ s2.den[33];
    s3_next.rem = DEN_W'(shifted[NUM_W-1:32]);
    s3_next.ovf = DEN_W'(shifted[NUM_W-1:32]) >= s3_next.den_mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= s1_next;
      s2 <= s2_next;
      s3 <= s3_next;
    end
  end

  assign out_data = s3;

endmodule

@@ design/apcu_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, carrying the item alongside.
// Depends on apcu_pkg.
`timescale 1ns / 1ps

module apcu_div import apcu_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_valid,
  input  pipe_t in_data,
  output logic  out_valid,
  output pipe_t out_data
);

  pipe_t st [DIV_STEPS];
  logic  vld [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    localparam int BIT = DIV_STEPS - 1 - k;
    pipe_t cur;
    pipe_t nxt;
    logic  cur_v;
    logic [DEN_W:0] trial;

    if (k == 0) begin : g_first
      assign cur = in_data;
      assign cur_v = in_valid;
    end else begin : g_rest
      assign cur = st[k-1];
      assign cur_v = vld[k-1];
    end

    always_comb begin
      nxt = cur;
      trial = {cur.rem, cur.num_mag[BIT]};
      if (trial >= {1'b0, cur.den_mag}) begin
        nxt.rem = DEN_W'(trial - {1'b0, cur.den_mag});
        nxt.quo[BIT] = 1'b1;
      end else begin
        nxt.rem = trial[DEN_W-1:0];
        nxt.quo[BIT] = 1'b0;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= cur_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[k] <= nxt;
      end
    end
  end

  assign out_valid = vld[DIV_STEPS-1];
  assign out_data = st[DIV_STEPS-1];

endmodule

@@ design/apcu_back.sv @@
// Back stages: quotient sign and clip, reaction and recovery products, final sums.
// Six register stages, the last being the output register; depends on apcu_pkg.
`timescale 1ns / 1ps

module apcu_back import apcu_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  cfg_t  cfg,
  input  logic  in_valid,
  input  pipe_t in_data,
  output logic  out_valid,
  output pipe_t out_data
);

  pipe_t b1, b2, b3, b4, b5, b6;
  pipe_t b1_next, b2_next, b3_next, b4_next, b5_next, b6_next;
  logic  v1, v2, v3, v4, v5;

  always_comb begin
    sat_t t;
    logic signed [31:0] quo_s;
    b1_next = in_data;
    quo_s = '0;
    if (!in_data.fault) begin
      b1_next.clip = b1_next.clip | in_data.m1r_clip;
      if (in_data.ovf) begin
        b1_next.clip = 1'b1;
        quo_s = in_data.neg ? Q_MIN : Q_MAX;
      end else begin
        t = sat32(in_data.neg ? -66'(in_data.quo) : 66'(in_data.quo));
        quo_s = t.v;
        b1_next.clip = b1_next.clip | t.clip;
      end
    end
    t = sat32(sx(ureg(cfg.eps)) + sx(quo_s));
    b1_next.rate = t.v;
    b1_next.clip = b1_next.clip | t.clip;
    b1_next.p_alap = mul64(ureg(cfg.alpha), in_data.lapc);
    b1_next.p_t1 = mul64(in_data.kke, in_data.ec_a);
    b1_next.p_t2 = mul64(in_data.kke, in_data.ec_b);
  end

  always_comb begin
    sat_t t;
    sat_t u;
    b2_next = b1;
    t = qmul(b1.p_alap);
    u = sat32(sx(b1.ec) + sx(t.v));
    b2_next.e1 = u.v;
    b2_next.clip = b2_next.clip | t.clip | u.clip;
    t = qmul(b1.p_t1);
    b2_next.t1 = t.v;
    b2_next.clip = b2_next.clip | t.clip;
    t = qmul(b1.p_t2);
    u = sat32(sx(b1.negr) - sx(t.v));
    b2_next.drive = u.v;
    b2_next.clip = b2_next.clip | t.clip | u.clip;
    b2_next.p_dtrate = mul64(ureg(cfg.dt), b1.rate);
  end

  always_comb begin
    sat_t t;
    b3_next = b2;
    b3_next.p_react = mul64(b2.t1, b2.ec_1);
    t = qmul(b2.p_dtrate);
    b3_next.dtrate = t.v;
    b3_next.clip = b3_next.clip | t.clip;
  end

  always_comb begin
    sat_t t;
    sat_t u;
    b4_next = b3;
    t = qmul(b3.p_react);
    u = sat32(sx(t.v) + sx(b3.er));
    b4_next.react2 = u.v;
    b4_next.clip = b4_next.clip | t.clip | u.clip;
  end

  always_comb begin
    b5_next = b4;
    b5_next.p_dtr = mul64(ureg(cfg.dt), b4.react2);
    b5_next.p_rd = mul64(b4.dtrate, b4.drive);
  end

  always_comb begin
    sat_t t;
    sat_t u;
    b6_next = b5;
    t = qmul(b5.p_dtr);
    u = sat32(sx(b5.e1) - sx(t.v));
    b6_next.e_new = u.v;
    b6_next.clip = b6_next.clip | t.clip | u.clip;
    t = qmul(b5.p_rd);
    u = sat32(sx(b5.r) + sx(t.v));
    b6_next.r_new = u.v;
    b6_next.clip = b6_next.clip | t.clip | u.clip;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1 <= b1_next;
      b2 <= b2_next;
      b3 <= b3_next;
      b4 <= b4_next;
      b5 <= b5_next;
      b6 <= b6_next;
    end
  end

  assign out_data = b6;

endmodule

@@ design/aliev_panfilov_cell_update_top.sv @@
// Top level of the Aliev-Panfilov cell update: stream ports, configuration registers
// and the front, divider and back pipeline sections; depends on apcu_pkg and all modules.
`timescale 1ns / 1ps

// One mesh cell is taken per clock cycle unless the output stalls; its updated excitation
// and recovery leave after three front stages, 32 stages of the divider that forms the
// recovery rate fraction (one quotient bit per stage) and six back stages, the last of
// which is the output register. The whole pipeline advances together whenever the output
// register is empty or its item is being taken, and s_axis_tready is high exactly then.
// Configuration registers may be written only while no item is in flight.

module aliev_panfilov_cell_update_top import apcu_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // e_center, e_north, e_south, e_east, e_west, recovery_in (32 bits each)
  input  logic [191:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // new_excitation, new_recovery (32 bits each)
  output logic [63:0]  m_axis_tdata,
  // saturated, divide_fault
  output logic [1:0]   m_axis_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [3:0]   cfg_index,
  input  logic [30:0]  cfg_data
);

  cfg_t  cfg;
  logic  en;
  logic  front_valid, div_valid;
  pipe_t front_data, div_data, back_data;

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alpha <= RST_ALPHA;
      cfg.dt <= RST_DT;
      cfg.kk <= RST_KK;
      cfg.ta <= RST_TA;
      cfg.tb <= RST_TB;
      cfg.eps <= RST_EPS;
      cfg.m1 <= RST_M1;
      cfg.m2 <= RST_M2;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ALPHA: cfg.alpha <= cfg_data;
        REG_DT:    cfg.dt <= cfg_data;
        REG_KK:    cfg.kk <= cfg_data;
        REG_TA:    cfg.ta <= cfg_data;
        REG_TB:    cfg.tb <= cfg_data;
        REG_EPS:   cfg.eps <= cfg_data;
        REG_M1:    cfg.m1 <= cfg_data;
        REG_M2:    cfg.m2 <= cfg_data;
        default: ;
      endcase
    end
  end

  apcu_front u_front (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .cfg         (cfg),
    .in_valid    (s_axis_tvalid),
    .e_center    (s_axis_tdata[31:0]),
    .e_north     (s_axis_tdata[63:32]),
    .e_south     (s_axis_tdata[95:64]),
    .e_east      (s_axis_tdata[127:96]),
    .e_west      (s_axis_tdata[159:128]),
    .recovery_in (s_axis_tdata[191:160]),
    .out_valid   (front_valid),
    .out_data    (front_data)
  );

  apcu_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (front_valid),
    .in_data   (front_data),
    .out_valid (div_valid),
    .out_data  (div_data)
  );

  apcu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .in_valid  (div_valid),
    .in_data   (div_data),
    .out_valid (m_axis_tvalid),
    .out_data  (back_data)
  );

  assign m_axis_tdata = {back_data.r_new, back_data.e_new};
  assign m_axis_tuser = {back_data.fault, back_data.clip};

  a_ready_follows_output: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("Input ready does not follow the output register state.");

  a_reset_empties: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("Output valid after reset.");

  a_fault_has_zero_divisor: assert property (@(posedge clk) disable iff (rst)
    (front_valid && front_data.fault) |-> (front_data.den_mag == '0))
    else $error("Divide fault raised for a non-zero divisor.");

endmodule
